[src/kbt_pkg.sv]
package kbt_pkg;

    // table geometry
    localparam int ENTRIES = 16;
    localparam int TASKS   = 16;
    localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef logic [IW-1:0] t_idx;

    // request codes
    localparam logic [1:0] OP_OPEN    = 2'd0;
    localparam logic [1:0] OP_WAIT    = 2'd1;
    localparam logic [1:0] OP_DESTROY = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_IDX = 2'd2;

    localparam logic [31:0] KEY_NONE  = 32'hFFFF_FFFF;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [31:0] key;
        logic [7:0]  goal;
        logic [7:0]  arrivals;
        logic [7:0]  users;
        logic [15:0] waiters;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_entry data;
    } t_wr;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  handle;
        logic        blocked;
        logic [15:0] release_mask;
    } t_result;

endpackage

[src/keyed_barrier_table_top.sv]
// channel | direction | handshake                  | payload
// request | in        | i_in_valid / o_in_stall    | opcode, key, goal, index, task
// result  | out       | o_out_valid / i_out_stall  | status, handle, blocked, mask
//
// open: one table entry per cycle is compared by the sequential key scan over 16
//   entries through one read port; the scan stops at the first key hit
// wait and destroy: read and update in the exec state, then result; no-op code and bad index: result only
// one request in flight; a new request is taken while the last result still waits
// reset is synchronous and active low; it frees every entry at once
// a stalled result holds; a finished request waits for the result register to empty or drain
module keyed_barrier_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_barrier_key,
    input  logic [7:0]         i_arrival_goal,
    input  logic [3:0]         i_entry_index,
    input  logic [3:0]         i_task_id,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [3:0]         o_handle,
    output logic               o_caller_blocked,
    output logic [15:0]        o_release_mask
);

    logic             busy;
    logic             in_xfer;
    kbt_pkg::t_idx    rd_addr;
    kbt_pkg::t_entry  rd_data;
    kbt_pkg::t_wr     wr;
    logic             res_free;
    logic             res_load;
    kbt_pkg::t_result res;

    logic             r_out_valid;
    kbt_pkg::t_result r_out;

    // input side is free whenever the sequencer is idle
    assign o_in_stall = busy;
    assign in_xfer    = i_in_valid && !busy;

    // result register can take a new value when empty or being drained
    assign res_free = !r_out_valid || !i_out_stall;

    kbt_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

    kbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_xfer),
        .i_opcode   (i_opcode),
        .i_key      ($unsigned(i_barrier_key)),
        .i_goal     (i_arrival_goal),
        .i_index    (i_entry_index),
        .i_task     (i_task_id),
        .o_busy     (busy),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr       (wr),
        .i_res_free (res_free),
        .o_res_load (res_load),
        .o_res      (res)
    );

    // output register, parts the result channel from the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_handle         = r_out.handle;
    assign o_caller_blocked = r_out.blocked;
    assign o_release_mask   = r_out.release_mask;

endmodule

[src/kbt_store.sv]
module kbt_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kbt_pkg::t_idx   i_rd_addr,
    output kbt_pkg::t_entry o_rd_data,
    input  kbt_pkg::t_wr    i_wr
);

    logic [31:0] r_key      [kbt_pkg::ENTRIES];
    logic [7:0]  r_goal     [kbt_pkg::ENTRIES];
    logic [7:0]  r_arrivals [kbt_pkg::ENTRIES];
    logic [7:0]  r_users    [kbt_pkg::ENTRIES];
    logic [15:0] r_waiters  [kbt_pkg::ENTRIES];

    // user count is the live flag, so it alone is cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kbt_pkg::ENTRIES; i++) begin
                r_users[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_users[i_wr.addr] <= i_wr.data.users;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_key[i_wr.addr]      <= i_wr.data.key;
            r_goal[i_wr.addr]     <= i_wr.data.goal;
            r_arrivals[i_wr.addr] <= i_wr.data.arrivals;
            r_waiters[i_wr.addr]  <= i_wr.data.waiters;
        end
    end

    assign o_rd_data.key      = r_key[i_rd_addr];
    assign o_rd_data.goal     = r_goal[i_rd_addr];
    assign o_rd_data.arrivals = r_arrivals[i_rd_addr];
    assign o_rd_data.users    = r_users[i_rd_addr];
    assign o_rd_data.waiters  = r_waiters[i_rd_addr];

endmodule

[src/kbt_ctrl.sv]
module kbt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_opcode,
    input  logic [31:0]      i_key,
    input  logic [7:0]       i_goal,
    input  logic [3:0]       i_index,
    input  logic [3:0]       i_task,
    output logic             o_busy,
    output kbt_pkg::t_idx    o_rd_addr,
    input  kbt_pkg::t_entry  i_rd_data,
    output kbt_pkg::t_wr     o_wr,
    input  logic             i_res_free,
    output logic             o_res_load,
    output kbt_pkg::t_result o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam kbt_pkg::t_idx LAST = kbt_pkg::t_idx'(kbt_pkg::ENTRIES - 1);

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_op;
    logic [31:0]      r_key;
    logic [7:0]       r_goal;
    logic [3:0]       r_index;
    logic [3:0]       r_task;
    kbt_pkg::t_idx    r_cnt, n_cnt;
    logic             r_free_found, n_free_found;
    kbt_pkg::t_idx    r_free_idx, n_free_idx;
    kbt_pkg::t_result r_res, n_res;

    logic             cur_live;
    logic             key_hit;
    logic             cur_free;
    logic [7:0]       arr_inc;
    logic             idx_bad;
    logic             task_ok;
    kbt_pkg::t_idx    alloc_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op    <= i_opcode;
            r_key   <= i_key;
            r_goal  <= i_goal;
            r_index <= i_index;
            r_task  <= i_task;
        end
        r_cnt        <= n_cnt;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_res        <= n_res;
    end

    // shared compare and count unit, fed by the one read port
    assign cur_live  = (i_rd_data.users != '0);
    assign cur_free  = !cur_live;
    assign key_hit   = cur_live && (i_rd_data.key == r_key);
    assign arr_inc   = (i_rd_data.arrivals == kbt_pkg::COUNT_MAX) ?
                       kbt_pkg::COUNT_MAX : i_rd_data.arrivals + 8'd1;
    assign idx_bad   = ({28'd0, i_index} >= kbt_pkg::ENTRIES);
    assign task_ok   = ({28'd0, r_task} < kbt_pkg::TASKS);
    assign alloc_idx = r_free_found ? r_free_idx : r_cnt;

    assign o_rd_addr = (r_state == S_SCAN) ? r_cnt : kbt_pkg::t_idx'(r_index);
    assign o_busy    = (r_state != S_IDLE);
    assign o_res     = r_res;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_res        = r_res;
        o_wr         = '0;
        o_wr.data    = i_rd_data;
        o_res_load   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res        = '0;
                    n_cnt        = '0;
                    n_free_found = 1'b0;
                    unique case (i_opcode)
                        kbt_pkg::OP_OPEN: n_state = S_SCAN;
                        kbt_pkg::OP_NONE: n_state = S_FIN;
                        default: begin
                            if (idx_bad) begin
                                n_res.status = kbt_pkg::ST_BAD_IDX;
                                n_state      = S_FIN;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (key_hit) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_cnt;
                    if (i_rd_data.users != kbt_pkg::COUNT_MAX) begin
                        o_wr.data.users = i_rd_data.users + 8'd1;
                    end
                    o_wr.data.goal = r_goal;
                    n_res.handle   = 4'(r_cnt);
                    n_state        = S_FIN;
                end else if (r_cnt == LAST) begin
                    if (r_free_found || cur_free) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = alloc_idx;
                        o_wr.data.key      = r_key;
                        o_wr.data.goal     = r_goal;
                        o_wr.data.arrivals = '0;
                        o_wr.data.users    = 8'd1;
                        o_wr.data.waiters  = '0;
                        n_res.handle       = 4'(alloc_idx);
                    end else begin
                        n_res.status = kbt_pkg::ST_FULL;
                    end
                    n_state = S_FIN;
                end else begin
                    if (cur_free && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_cnt;
                    end
                    n_cnt = r_cnt + kbt_pkg::t_idx'(1);
                end
            end

            S_EXEC: begin
                o_wr.addr = kbt_pkg::t_idx'(r_index);
                if (cur_free) begin
                    n_res.status = kbt_pkg::ST_BAD_IDX;
                end else if (r_op == kbt_pkg::OP_WAIT) begin
                    o_wr.en = 1'b1;
                    if (arr_inc >= i_rd_data.goal) begin
                        o_wr.data.arrivals = '0;
                        o_wr.data.waiters  = '0;
                        n_res.release_mask = i_rd_data.waiters;
                    end else begin
                        o_wr.data.arrivals = arr_inc;
                        if (task_ok) begin
                            o_wr.data.waiters = i_rd_data.waiters | (16'd1 << r_task);
                        end
                        n_res.blocked = 1'b1;
                    end
                end else begin
                    o_wr.en = 1'b1;
                    o_wr.data.key      = kbt_pkg::KEY_NONE;
                    o_wr.data.users    = '0;
                    o_wr.data.arrivals = '0;
                    o_wr.data.waiters  = '0;
                    n_res.release_mask = i_rd_data.waiters;
                end
                n_state = S_FIN;
            end

            S_FIN: begin
                if (i_res_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

endmodule

[src/kbt_checker.sv]
module kbt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_status,
    input logic [3:0]         o_handle,
    input logic               o_caller_blocked,
    input logic [15:0]        o_release_mask
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
        $stable(o_handle) && $stable(o_caller_blocked) && $stable(o_release_mask))
        else $error("result changed under stall");

    // a request in flight keeps the input side closed
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while another is in flight");

    // a blocked caller releases nobody
    a_blocked_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_caller_blocked |->
        o_status == kbt_pkg::ST_OK && o_release_mask == 16'd0 && o_handle == 4'd0)
        else $error("blocked result carries other fields");

    // error results carry nothing else
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != kbt_pkg::ST_OK |->
        !o_caller_blocked && o_release_mask == 16'd0 && o_handle == 4'd0)
        else $error("error result carries other fields");

    // nothing shows right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

endmodule

bind keyed_barrier_table_top kbt_checker u_kbt_checker (.*);
